// ===== hw/rtl/iac_pkg.sv =====
// iac_pkg: shared types, codes and reset constants of the IMU air cursor tracker.
// No dependencies; compiled first.
package iac_pkg;

   // Item field widths
   localparam int ACCEL_W  = 16;
   localparam int DT_W     = 16;
   localparam int CURSOR_W = 20;
   localparam int VEL_W    = 21;
   localparam int LIN_W    = 17;
   localparam int PHASE_W  = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_DEADZONE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_DEADZONE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_FACTOR    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_ALPHA     = 3'd7;

   // Register reset values
   localparam logic [11:0] SCREEN_WIDTH_RST      = 12'd800;
   localparam logic [11:0] SCREEN_HEIGHT_RST     = 12'd450;
   localparam logic [11:0] ACCEL_DEADZONE_RST    = 12'd205;
   localparam logic [7:0]  VELOCITY_DEADZONE_RST = 8'd8;
   localparam logic [11:0] VELOCITY_LIMIT_RST    = 12'd2500;
   localparam logic [12:0] ACCEL_GAIN_RST        = 13'd2700;
   localparam logic [15:0] DAMPING_FACTOR_RST    = 16'd58982;
   localparam logic [15:0] GRAVITY_ALPHA_RST     = 16'd65208;

   // Cursor starts at the center of the reset screen
   localparam logic [CURSOR_W-1:0] CURSOR_X_RST = {1'b0, SCREEN_WIDTH_RST, 7'd0};
   localparam logic [CURSOR_W-1:0] CURSOR_Y_RST = {1'b0, SCREEN_HEIGHT_RST, 7'd0};

   // Item codes
   localparam logic REQ_SAMPLE   = 1'b0;
   localparam logic REQ_RECENTER = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_CALIB  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_PRIMED = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_TRACK  = 2'd2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV_GO,
      ST_DIV_RUN,
      ST_GRAV_HI,
      ST_GRAV_LO,
      ST_GRAV_A,
      ST_GRAV_END,
      ST_ACC_GAIN,
      ST_ACC_DT,
      ST_VEL_SUM,
      ST_VEL_DAMP,
      ST_VEL_LIM,
      ST_POS_MUL,
      ST_POS_END,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/iac_req_if.sv =====
// iac_req_if: input channel of the cursor tracker, valid/ready with one sample item.
// Depends on iac_pkg.
interface iac_req_if;
   import iac_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [ACCEL_W-1:0] accel_x;
   logic signed [ACCEL_W-1:0] accel_y;
   logic [DT_W-1:0]           frame_time;

   modport source (output valid, req_type, accel_x, accel_y, frame_time, input ready);
   modport sink   (input valid, req_type, accel_x, accel_y, frame_time, output ready);
endinterface

// ===== hw/rtl/iac_rsp_if.sv =====
// iac_rsp_if: result channel of the cursor tracker, valid/ready with one cursor item.
// Depends on iac_pkg.
interface iac_rsp_if;
   import iac_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [PHASE_W-1:0]        phase;
   logic [CURSOR_W-1:0]       cursor_x_out;
   logic [CURSOR_W-1:0]       cursor_y_out;
   logic signed [VEL_W-1:0]   velocity_x_out;
   logic signed [VEL_W-1:0]   velocity_y_out;
   logic signed [LIN_W-1:0]   linear_x_out;
   logic signed [LIN_W-1:0]   linear_y_out;

   modport source (output valid, phase, cursor_x_out, cursor_y_out, velocity_x_out,
                   velocity_y_out, linear_x_out, linear_y_out, input ready);
   modport sink   (input valid, phase, cursor_x_out, cursor_y_out, velocity_x_out,
                   velocity_y_out, linear_x_out, linear_y_out, output ready);
endinterface

// ===== hw/rtl/iac_divider.sv =====
// iac_divider: division of an unsigned value by a fixed divisor by a constant reciprocal
// multiply; quotient registered in the cycle after start, exact for every NUM_W-bit input. No package.
module iac_divider #(
   parameter int NUM_W = 24,
   parameter int DEN   = 120
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   // floor(n / DEN) = floor(n * ceil(2^SHIFT / DEN) / 2^SHIFT) for n < 2^NUM_W
   localparam int SHIFT  = NUM_W + $clog2(DEN);
   localparam int PROD_W = 2 * NUM_W + 1;
   localparam logic [NUM_W:0] RECIP =
      (NUM_W + 1)'(((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN));

   logic [PROD_W-1:0] prod_ff;
   logic              done_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Reciprocal product
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {{(NUM_W + 1){1'b0}}, numer} * {{NUM_W{1'b0}}, RECIP};
      end
   end

   assign done = done_ff;
   assign quot = NUM_W'(prod_ff[PROD_W-1:SHIFT]);

endmodule

// ===== hw/rtl/imu_air_cursor_tracker.sv =====
// imu_air_cursor_tracker: accelerometer-driven cursor with bias calibration and gravity tracking.
// Recenter, calibration and priming items go from dispatch straight to the finish step; tracking
// items run both axes through 11 steps of one shared 32x18 multiplier; the sample that ends
// calibration computes the bias of each axis by a reciprocal multiply.
// One item at a time; the result register lets the next item enter while a result waits.
// Synchronous active-high reset: registers to defaults, cursor at the reset screen center.
module imu_air_cursor_tracker #(
   parameter int CALIB_SAMPLES = 120
) (
   input  logic                            clock,
   input  logic                            reset,
   iac_req_if.sink                         req_chan,
   iac_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [iac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iac_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import iac_pkg::*;

   localparam int SUM_W = 17 + $clog2(CALIB_SAMPLES);
   localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CALIB_LAST = CNT_W'(CALIB_SAMPLES);
   localparam logic [SUM_W-1:0] CALIB_HALF = SUM_W'(CALIB_SAMPLES / 2);

   // Configuration registers
   logic [11:0] width_ff, height_ff, adz_ff, vlim_ff;
   logic [7:0]  vdz_ff;
   logic [12:0] gain_ff;
   logic [15:0] damp_ff, alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RST;
         height_ff <= SCREEN_HEIGHT_RST;
         adz_ff    <= ACCEL_DEADZONE_RST;
         vdz_ff    <= VELOCITY_DEADZONE_RST;
         vlim_ff   <= VELOCITY_LIMIT_RST;
         gain_ff   <= ACCEL_GAIN_RST;
         damp_ff   <= DAMPING_FACTOR_RST;
         alpha_ff  <= GRAVITY_ALPHA_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:      width_ff  <= csr_write_data[11:0];
            CSR_SCREEN_HEIGHT:     height_ff <= csr_write_data[11:0];
            CSR_ACCEL_DEADZONE:    adz_ff    <= csr_write_data[11:0];
            CSR_VELOCITY_DEADZONE: vdz_ff    <= csr_write_data[7:0];
            CSR_VELOCITY_LIMIT:    vlim_ff   <= csr_write_data[11:0];
            CSR_ACCEL_GAIN:        gain_ff   <= csr_write_data[12:0];
            CSR_DAMPING_FACTOR:    damp_ff   <= csr_write_data[15:0];
            CSR_GRAVITY_ALPHA:     alpha_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer and tracker state
   state_type state_ff, state_in;
   logic      axis_ff;
   logic      calib_done_ff, primed_ff;
   logic [CNT_W-1:0]        calib_cnt_ff;
   logic signed [SUM_W-1:0] sum_ff   [2];
   logic signed [15:0]      bias_ff  [2];
   logic signed [33:0]      grav_ff  [2];
   logic signed [VEL_W-1:0] vel_ff   [2];
   logic [CURSOR_W-1:0]     cur_ff   [2];
   logic signed [LIN_W-1:0] lin_ff   [2];
   logic [PHASE_W-1:0]      phase_ff;

   // Captured item and working registers
   logic                      type_ff;
   logic signed [ACCEL_W-1:0] x_ff, y_ff;
   logic [DT_W-1:0]           dt_ff;
   logic signed [51:0]        acc_ff;
   logic signed [LIN_W-1:0]   lterm_ff;
   logic signed [27:0]        vsum_ff;
   logic signed [VEL_W-1:0]   vnew_ff;
   logic signed [49:0]        prod_ff;

   // Result register
   logic                      rsp_valid_ff;
   logic [PHASE_W-1:0]        rsp_phase_ff;
   logic [CURSOR_W-1:0]       rsp_cx_ff, rsp_cy_ff;
   logic signed [VEL_W-1:0]   rsp_vx_ff, rsp_vy_ff;
   logic signed [LIN_W-1:0]   rsp_lx_ff, rsp_ly_ff;

   logic req_accept, rsp_free;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // Bias-corrected axis values, Y inverted
   logic signed [16:0] a_x, a_y, a_cur;
   logic signed [33:0] g_cur;
   logic signed [VEL_W-1:0] v_cur;
   logic [CURSOR_W-1:0] p_cur;
   logic [11:0] size_cur;

   always_comb begin
      a_x      = {x_ff[15], x_ff} - {bias_ff[0][15], bias_ff[0]};
      a_y      = {bias_ff[1][15], bias_ff[1]} - {y_ff[15], y_ff};
      a_cur    = axis_ff ? a_y : a_x;
      g_cur    = grav_ff[axis_ff];
      v_cur    = vel_ff[axis_ff];
      p_cur    = cur_ff[axis_ff];
      size_cur = axis_ff ? height_ff : width_ff;
   end

   // Shared multiplier: operands chosen by step, product registered
   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;
   logic [16:0]        alpha_rest;

   always_comb begin
      alpha_rest = 17'h10000 - {1'b0, alpha_ff};
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_GRAV_HI: begin
            mul_a = $signed(g_cur[33:16]);
            mul_b = $signed({2'b00, alpha_ff});
         end
         ST_GRAV_LO: begin
            mul_a = $signed({16'd0, g_cur[15:0]});
            mul_b = $signed({2'b00, alpha_ff});
         end
         ST_GRAV_A: begin
            mul_a = a_cur;
            mul_b = $signed({1'b0, alpha_rest});
         end
         ST_ACC_GAIN: begin
            mul_a = lterm_ff;
            mul_b = $signed({5'd0, gain_ff});
         end
         ST_ACC_DT: begin
            mul_a = $signed(prod_ff[31:0]);
            mul_b = $signed({2'b00, dt_ff});
         end
         ST_VEL_DAMP: begin
            mul_a = vsum_ff;
            mul_b = $signed({2'b00, damp_ff});
         end
         ST_POS_MUL: begin
            mul_a = vnew_ff;
            mul_b = $signed({2'b00, dt_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Gravity update, linear acceleration and acceleration deadzone
   logic signed [51:0] grav_mix, grav_rnd;
   logic signed [33:0] g_new;
   logic signed [34:0] g_half;
   logic signed [19:0] lin_wide;
   logic signed [LIN_W-1:0] lin_sat, adz_pos, adz_neg, lin_dz;

   always_comb begin
      grav_mix = acc_ff + (prod_ff <<< 16);
      grav_rnd = grav_mix + 52'sd32768;
      g_new    = grav_rnd[49:16];
      g_half   = {g_new[33], g_new} + 35'sd32768;
      lin_wide = {{3{a_cur[16]}}, a_cur} - {g_half[34], g_half[34:16]};
      if (lin_wide > 20'sd65535) begin
         lin_sat = 17'sd65535;
      end else if (lin_wide < -20'sd65536) begin
         lin_sat = -17'sd65536;
      end else begin
         lin_sat = lin_wide[16:0];
      end
      adz_pos = $signed({5'd0, adz_ff});
      adz_neg = -adz_pos;
      lin_dz  = ((lin_sat < adz_pos) && (lin_sat > adz_neg)) ? '0 : lin_sat;
   end

   // Velocity: integrate, damp, deadzone, clamp
   logic signed [49:0] dv_rnd, vd_rnd, dp_rnd;
   logic signed [25:0] dv;
   logic signed [28:0] vd, vdz_pos, vdz_neg, vmax_pos, vmax_neg, v_dz, v_clamp;

   always_comb begin
      dv_rnd   = prod_ff + 50'sd524288;
      dv       = dv_rnd[45:20];
      vd_rnd   = prod_ff + 50'sd32768;
      vd       = vd_rnd[44:16];
      vdz_pos  = $signed({13'd0, vdz_ff, 8'd0});
      vdz_neg  = -vdz_pos;
      vmax_pos = $signed({9'd0, vlim_ff, 8'd0});
      vmax_neg = -vmax_pos;
      v_dz     = ((vd < vdz_pos) && (vd > vdz_neg)) ? '0 : vd;
      if (v_dz > vmax_pos) begin
         v_clamp = vmax_pos;
      end else if (v_dz < vmax_neg) begin
         v_clamp = vmax_neg;
      end else begin
         v_clamp = v_dz;
      end
   end

   // Position: integrate and clamp to the screen
   logic signed [20:0] dp;
   logic signed [21:0] p_sum, p_edge;

   always_comb begin
      dp_rnd = prod_ff + 50'sd32768;
      dp     = dp_rnd[36:16];
      p_sum  = $signed({2'b00, p_cur}) + {dp[20], dp};
      p_edge = $signed({2'b00, size_cur, 8'd0});
   end

   // Bias divider, shared by both axes
   logic                    div_start, div_done;
   logic [SUM_W-1:0]        div_numer, div_quot, sum_mag;
   logic signed [SUM_W-1:0] sum_cur;
   logic [16:0]             quot_neg;

   always_comb begin
      sum_cur   = sum_ff[axis_ff];
      sum_mag   = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
      div_numer = sum_mag + CALIB_HALF;
      div_start = (state_ff == ST_DIV_GO);
      quot_neg  = 17'd0 - div_quot[16:0];
   end

   iac_divider #(
      .NUM_W (SUM_W),
      .DEN   (CALIB_SAMPLES)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Next state
   logic [CNT_W-1:0] calib_cnt_next;
   assign calib_cnt_next = calib_cnt_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_accept) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (type_ff == REQ_RECENTER) begin
               state_in = ST_DONE;
            end else if (!calib_done_ff) begin
               state_in = (calib_cnt_next == CALIB_LAST) ? ST_DIV_GO : ST_DONE;
            end else if (!primed_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_GRAV_HI;
            end
         end
         ST_DIV_GO:   state_in = ST_DIV_RUN;
         ST_DIV_RUN:  if (div_done) state_in = axis_ff ? ST_DONE : ST_DIV_GO;
         ST_GRAV_HI:  state_in = ST_GRAV_LO;
         ST_GRAV_LO:  state_in = ST_GRAV_A;
         ST_GRAV_A:   state_in = ST_GRAV_END;
         ST_GRAV_END: state_in = ST_ACC_GAIN;
         ST_ACC_GAIN: state_in = ST_ACC_DT;
         ST_ACC_DT:   state_in = ST_VEL_SUM;
         ST_VEL_SUM:  state_in = ST_VEL_DAMP;
         ST_VEL_DAMP: state_in = ST_VEL_LIM;
         ST_VEL_LIM:  state_in = ST_POS_MUL;
         ST_POS_MUL:  state_in = ST_POS_END;
         ST_POS_END:  state_in = axis_ff ? ST_DONE : ST_GRAV_HI;
         ST_DONE:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Tracker state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff       <= 1'b0;
         calib_done_ff <= 1'b0;
         primed_ff     <= 1'b0;
         calib_cnt_ff  <= '0;
         phase_ff      <= PHASE_CALIB;
         for (int i = 0; i < 2; i++) begin
            sum_ff[i]  <= '0;
            bias_ff[i] <= '0;
            grav_ff[i] <= '0;
            vel_ff[i]  <= '0;
         end
         cur_ff[0] <= CURSOR_X_RST;
         cur_ff[1] <= CURSOR_Y_RST;
      end else begin
         unique case (state_ff)
            ST_DISPATCH: begin
               axis_ff <= 1'b0;
               if (type_ff == REQ_RECENTER) begin
                  cur_ff[0] <= {1'b0, width_ff, 7'd0};
                  cur_ff[1] <= {1'b0, height_ff, 7'd0};
                  vel_ff[0] <= '0;
                  vel_ff[1] <= '0;
                  phase_ff  <= primed_ff ? PHASE_TRACK : PHASE_CALIB;
               end else if (!calib_done_ff) begin
                  sum_ff[0]    <= sum_ff[0] + SUM_W'(x_ff);
                  sum_ff[1]    <= sum_ff[1] + SUM_W'(y_ff);
                  calib_cnt_ff <= calib_cnt_next;
                  phase_ff     <= PHASE_CALIB;
               end else if (!primed_ff) begin
                  grav_ff[0] <= {a_x[16], a_x, 16'd0};
                  grav_ff[1] <= {a_y[16], a_y, 16'd0};
                  primed_ff  <= 1'b1;
                  phase_ff   <= PHASE_PRIMED;
               end else begin
                  phase_ff <= PHASE_TRACK;
               end
            end
            ST_DIV_RUN: begin
               if (div_done) begin
                  bias_ff[axis_ff] <= sum_cur[SUM_W-1] ? quot_neg[15:0] : div_quot[15:0];
                  axis_ff          <= 1'b1;
                  if (axis_ff) calib_done_ff <= 1'b1;
               end
            end
            ST_GRAV_END: grav_ff[axis_ff] <= g_new;
            ST_POS_END: begin
               axis_ff <= 1'b1;
               if (p_sum < 22'sd0) begin
                  cur_ff[axis_ff] <= '0;
                  vel_ff[axis_ff] <= '0;
               end else if (p_sum > p_edge) begin
                  cur_ff[axis_ff] <= p_edge[19:0];
                  vel_ff[axis_ff] <= '0;
               end else begin
                  cur_ff[axis_ff] <= p_sum[19:0];
                  vel_ff[axis_ff] <= vnew_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Working registers and captured item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff   <= req_chan.req_type;
         x_ff      <= req_chan.accel_x;
         y_ff      <= req_chan.accel_y;
         dt_ff     <= req_chan.frame_time;
         lin_ff[0] <= '0;
         lin_ff[1] <= '0;
      end
      case (state_ff)
         ST_GRAV_LO:  acc_ff <= prod_ff <<< 16;
         ST_GRAV_A:   acc_ff <= acc_ff + prod_ff;
         ST_GRAV_END: begin
            lin_ff[axis_ff] <= lin_sat;
            lterm_ff        <= lin_dz;
         end
         ST_VEL_SUM:  vsum_ff <= {{7{v_cur[20]}}, v_cur} + {{2{dv[25]}}, dv};
         ST_VEL_LIM:  vnew_ff <= v_clamp[20:0];
         default: ;
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_phase_ff <= phase_ff;
         rsp_cx_ff    <= cur_ff[0];
         rsp_cy_ff    <= cur_ff[1];
         rsp_vx_ff    <= vel_ff[0];
         rsp_vy_ff    <= vel_ff[1];
         rsp_lx_ff    <= lin_ff[0];
         rsp_ly_ff    <= lin_ff[1];
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.phase         = rsp_phase_ff;
   assign rsp_chan.cursor_x_out  = rsp_cx_ff;
   assign rsp_chan.cursor_y_out  = rsp_cy_ff;
   assign rsp_chan.velocity_x_out = rsp_vx_ff;
   assign rsp_chan.velocity_y_out = rsp_vy_ff;
   assign rsp_chan.linear_x_out  = rsp_lx_ff;
   assign rsp_chan.linear_y_out  = rsp_ly_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_chan.ready)
      else $error("input taken while an item is in work");

   a_div_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_RUN))
      else $error("divider finished outside the bias step");

   a_calib_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(calib_done_ff))
      else $error("calibration flag dropped");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the finish step");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_phase_ff == PHASE_TRACK)) |->
         ((rsp_cx_ff <= {width_ff, 8'd0}) && (rsp_cy_ff <= {height_ff, 8'd0})))
      else $error("cursor beyond the screen edge");

endmodule
